// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl files
// all checks run on clk_i and are off while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge
`define HRF_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("hrf assertion failed");

// when ante holds, cons must hold in the following cycle
`define HRF_ASSERT_NEXT(label, ante, cons) \
  `HRF_ASSERT(label, (ante) |=> (cons))

`endif

// ===== rtl/hrf_pkg.sv =====
package hrf_pkg;

  // body counter width
  localparam int unsigned COUNT_BITS = 32;

  // limits of the parsed values
  localparam logic [15:0] CODE_MAX = 16'hFFFF;
  localparam logic [30:0] LEN_MAX  = 31'h7FFF_FFFF;

  // characters the parser looks for
  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_0   = 8'h30;
  localparam logic [7:0] CHAR_9   = 8'h39;
  localparam logic [7:0] CHAR_C   = 8'h43;

  // length header prefix, first character in the top byte
  localparam logic [127:0] PREFIX_STR = "Content-Length: ";

  typedef enum logic [1:0] {
    CODE_WAIT,
    CODE_DIGITS,
    CODE_DONE
  } code_phase_e;

  typedef enum logic [1:0] {
    LEN_SEEK,
    LEN_DIGITS,
    LEN_DONE
  } len_phase_e;

  // one input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_end;
    logic       new_response;
  } item_t;

  // one result item
  typedef struct packed {
    logic        header_valid;
    logic [15:0] status_code;
    logic        code_valid;
    logic [30:0] content_length;
    logic        length_valid;
    logic [31:0] body_bytes;
    logic        data_complete;
  } res_t;

  // prefix character at a given match position
  function automatic logic [7:0] prefix_char(logic [3:0] idx);
    logic [3:0] rev;
    rev = 4'd15 - idx;
    return PREFIX_STR[{rev, 3'b000} +: 8];
  endfunction

  // header terminator character: CR LF CR LF
  function automatic logic [7:0] sep_char(logic [1:0] pos);
    return pos[0] ? CHAR_LF : CHAR_CR;
  endfunction

endpackage

// ===== rtl/hrf_in_if.sv =====
interface hrf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_end;
  logic       new_response;

  modport source (output valid, output data_byte, output chunk_end,
                  output new_response, input ready);
  modport sink (input valid, input data_byte, input chunk_end,
                input new_response, output ready);
endinterface

// ===== rtl/hrf_out_if.sv =====
interface hrf_out_if;
  logic        valid;
  logic        ready;
  logic        header_valid;
  logic [15:0] status_code;
  logic        code_valid;
  logic [30:0] content_length;
  logic        length_valid;
  logic [31:0] body_bytes;
  logic        data_complete;

  modport source (output valid, output header_valid, output status_code,
                  output code_valid, output content_length, output length_valid,
                  output body_bytes, output data_complete, input ready);
  modport sink (input valid, input header_valid, input status_code,
                input code_valid, input content_length, input length_valid,
                input body_bytes, input data_complete, output ready);
endinterface

// ===== rtl/hrf_core.sv =====
module hrf_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           acc_i,
  input  hrf_pkg::item_t item_i,
  output hrf_pkg::res_t  res_o
);

  // parser state
  logic [1:0]                     sep_q, sep_d;
  logic                           header_q, header_d;
  hrf_pkg::code_phase_e           code_phase_q, code_phase_d;
  logic [15:0]                    code_val_q, code_val_d;
  logic                           code_seen_q, code_seen_d;
  logic [3:0]                     prefix_q, prefix_d;
  hrf_pkg::len_phase_e            len_phase_q, len_phase_d;
  logic [30:0]                    len_val_q, len_val_d;
  logic                           len_ok_q, len_ok_d;
  logic [hrf_pkg::COUNT_BITS-1:0] body_q, body_d;
  logic                           drop_q, drop_d;

  logic [7:0]  c;
  logic        fresh;
  logic        is_digit;
  logic [3:0]  digit;
  logic [19:0] code_acc;
  logic [34:0] len_acc;
  logic [63:0] body_wide;

  assign c        = item_i.data_byte;
  assign fresh    = item_i.new_response;
  assign is_digit = c inside {[hrf_pkg::CHAR_0 : hrf_pkg::CHAR_9]};
  assign digit    = c[3:0];

  // next state for the accepted byte
  always_comb begin
    sep_d        = fresh ? 2'd0 : sep_q;
    header_d     = fresh ? 1'b0 : header_q;
    code_phase_d = fresh ? hrf_pkg::CODE_WAIT : code_phase_q;
    code_val_d   = fresh ? 16'd0 : code_val_q;
    code_seen_d  = fresh ? 1'b0 : code_seen_q;
    prefix_d     = fresh ? 4'd0 : prefix_q;
    len_phase_d  = fresh ? hrf_pkg::LEN_SEEK : len_phase_q;
    len_val_d    = fresh ? 31'd0 : len_val_q;
    len_ok_d     = fresh ? 1'b0 : len_ok_q;
    body_d       = fresh ? '0 : body_q;
    drop_d       = fresh ? 1'b0 : drop_q;

    // decimal accumulate on the values before this byte
    code_acc = 20'(code_val_d) * 20'd10 + 20'(digit);
    len_acc  = 35'(len_val_d) * 35'd10 + 35'(digit);

    if (drop_d) begin
      if (item_i.chunk_end) drop_d = 1'b0;
    end else if (c == hrf_pkg::CHAR_NUL) begin
      drop_d = !item_i.chunk_end;
    end else if (header_d) begin
      // body byte, saturating count
      if (body_d != '1) body_d = body_d + {{(hrf_pkg::COUNT_BITS-1){1'b0}}, 1'b1};
    end else begin
      // status code field
      case (code_phase_d)
        hrf_pkg::CODE_WAIT: begin
          if (c == hrf_pkg::CHAR_SP) code_phase_d = hrf_pkg::CODE_DIGITS;
        end
        hrf_pkg::CODE_DIGITS: begin
          if (is_digit) begin
            code_val_d  = (code_acc > 20'(hrf_pkg::CODE_MAX)) ? hrf_pkg::CODE_MAX
                                                             : code_acc[15:0];
            code_seen_d = 1'b1;
          end else begin
            code_phase_d = hrf_pkg::CODE_DONE;
          end
        end
        default: ;
      endcase

      // content length prefix and value
      case (len_phase_d)
        hrf_pkg::LEN_SEEK: begin
          if (c == hrf_pkg::prefix_char(prefix_d)) begin
            if (prefix_d == 4'd15) begin
              prefix_d    = 4'd0;
              len_phase_d = hrf_pkg::LEN_DIGITS;
            end else begin
              prefix_d = prefix_d + 4'd1;
            end
          end else begin
            prefix_d = (c == hrf_pkg::CHAR_C) ? 4'd1 : 4'd0;
          end
        end
        hrf_pkg::LEN_DIGITS: begin
          if (is_digit) begin
            if (len_acc > 35'(hrf_pkg::LEN_MAX)) begin
              len_ok_d    = 1'b0;
              len_phase_d = hrf_pkg::LEN_DONE;
            end else begin
              len_val_d = len_acc[30:0];
              len_ok_d  = 1'b1;
            end
          end else if (!len_ok_d && (c == hrf_pkg::CHAR_SP || c == hrf_pkg::CHAR_TAB)) begin
            // leading blank, skip
          end else begin
            len_phase_d = hrf_pkg::LEN_DONE;
          end
        end
        default: ;
      endcase

      // header terminator
      if (c == hrf_pkg::sep_char(sep_d)) begin
        if (sep_d == 2'd3) begin
          sep_d    = 2'd0;
          header_d = 1'b1;
        end else begin
          sep_d = sep_d + 2'd1;
        end
      end else begin
        sep_d = (c == hrf_pkg::CHAR_CR) ? 2'd1 : 2'd0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q        <= 2'd0;
      header_q     <= 1'b0;
      code_phase_q <= hrf_pkg::CODE_WAIT;
      code_val_q   <= 16'd0;
      code_seen_q  <= 1'b0;
      prefix_q     <= 4'd0;
      len_phase_q  <= hrf_pkg::LEN_SEEK;
      len_val_q    <= 31'd0;
      len_ok_q     <= 1'b0;
      body_q       <= '0;
      drop_q       <= 1'b0;
    end else if (acc_i) begin
      sep_q        <= sep_d;
      header_q     <= header_d;
      code_phase_q <= code_phase_d;
      code_val_q   <= code_val_d;
      code_seen_q  <= code_seen_d;
      prefix_q     <= prefix_d;
      len_phase_q  <= len_phase_d;
      len_val_q    <= len_val_d;
      len_ok_q     <= len_ok_d;
      body_q       <= body_d;
      drop_q       <= drop_d;
    end
  end

  // result from the updated state
  assign body_wide = 64'(body_d);

  always_comb begin
    res_o.header_valid   = header_d;
    res_o.status_code    = code_val_d;
    res_o.code_valid     = code_seen_d;
    res_o.content_length = len_val_d;
    res_o.length_valid   = len_ok_d;
    res_o.body_bytes     = (|body_wide[63:32]) ? 32'hFFFF_FFFF : body_wide[31:0];
    res_o.data_complete  = header_d && len_ok_d && (body_wide == 64'(len_val_d));
  end

endmodule

// ===== rtl/http_response_framer_unit.sv =====
// Frames one HTTP response that arrives one byte per item: it tracks the
// status code after the first space, the Content-Length value inside the
// header, the CR LF CR LF header end and the count of body bytes, and
// gives one result item for every byte taken. A NUL byte drops itself and
// the rest of its chunk; new_response clears all state before its byte.
// The block takes one byte every cycle while no result waits or the waiting
// result is taken in the same cycle; a byte's result appears in the output
// register in the cycle after the byte is accepted. The parser state update
// (the decimal multiply-accumulate of the length value and the body count
// compare) is combinational.
`include "assert_macros.svh"

module http_response_framer_unit (
  input logic      clk_i,
  input logic      rst_ni,
  hrf_in_if.sink   in_i,
  hrf_out_if.source out_o
);

  logic           in_acc;
  hrf_pkg::item_t item;
  hrf_pkg::res_t  res_next;
  hrf_pkg::res_t  res_q;
  logic           out_valid_q;

  // input handshake: free output slot or result leaving now
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  assign item.data_byte    = in_i.data_byte;
  assign item.chunk_end    = in_i.chunk_end;
  assign item.new_response = in_i.new_response;

  // parser state and result logic
  hrf_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (in_acc),
    .item_i (item),
    .res_o  (res_next)
  );

  // output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_next;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.header_valid   = res_q.header_valid;
  assign out_o.status_code    = res_q.status_code;
  assign out_o.code_valid     = res_q.code_valid;
  assign out_o.content_length = res_q.content_length;
  assign out_o.length_valid   = res_q.length_valid;
  assign out_o.body_bytes     = res_q.body_bytes;
  assign out_o.data_complete  = res_q.data_complete;

  // an accepted item always leaves a result behind
  `HRF_ASSERT_NEXT(a_acc_gives_result, in_acc, out_valid_q)
  // completion needs a finished header and a valid length
  `HRF_ASSERT(a_complete_needs_frame,
              !out_valid_q || !res_q.data_complete ||
              (res_q.header_valid && res_q.length_valid))
  // body bytes are only counted after the header end
  `HRF_ASSERT(a_body_after_header,
              !out_valid_q || res_q.body_bytes == 32'd0 || res_q.header_valid)
  // a status code without digits stays zero
  `HRF_ASSERT(a_code_zero_without_digit,
              !out_valid_q || res_q.code_valid || res_q.status_code == 16'd0)

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned RANDOM_BYTES = 700;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned DIR_ROWS     = 11;
  localparam logic [63:0] BODY_MAX     = {64{1'b1}} >> (64 - hrf_pkg::COUNT_BITS);

  typedef enum {
    SINK_OPEN,
    SINK_COIN,
    SINK_THIRD,
    SINK_MOSTLY
  } sink_mode_e;

  // one directed row: a run of bytes, '@' stands for a NUL byte,
  // want is the result of the row's last byte when pinned
  typedef struct {
    string         text;
    bit            fresh;
    bit            closes_chunk;
    bit            pinned;
    hrf_pkg::res_t want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  hrf_in_if  in_if ();
  hrf_out_if out_if ();

  http_response_framer_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // framing state mirrored by the predictor
  logic [2:0]           sep_cnt;
  logic                 hdr_seen;
  hrf_pkg::code_phase_e code_ph;
  logic [15:0]          code_val;
  logic                 code_dig;
  logic [4:0]           pfx_cnt;
  hrf_pkg::len_phase_e  len_ph;
  logic [30:0]          len_val;
  logic                 len_good;
  logic [63:0]          body_cnt;
  logic                 dropping;

  hrf_pkg::res_t  framing_due[$];
  hrf_pkg::item_t pending[$];
  bit             pin_on;
  hrf_pkg::res_t  pin_res;
  int unsigned    burst_left;
  int unsigned    bytes_sent;
  int unsigned    mismatches;
  int unsigned    cycles = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{"@", 1'b1, 1'b1, 1'b1, '{1'b0, 16'd0, 1'b0, 31'd0, 1'b0, 32'd0, 1'b0}},
    '{"HTTP/1.1 99999 OK\015\012", 1'b0, 1'b0, 1'b1,
      '{1'b0, hrf_pkg::CODE_MAX, 1'b1, 31'd0, 1'b0, 32'd0, 1'b0}},
    '{"Content-Length: \011 7\015\012", 1'b0, 1'b1, 1'b1,
      '{1'b0, hrf_pkg::CODE_MAX, 1'b1, 31'd7, 1'b1, 32'd0, 1'b0}},
    '{"ab@zz", 1'b0, 1'b1, 1'b0, '0},
    '{"\015\012\015\012", 1'b0, 1'b0, 1'b1,
      '{1'b1, hrf_pkg::CODE_MAX, 1'b1, 31'd7, 1'b1, 32'd0, 1'b0}},
    '{"abcde\377g", 1'b0, 1'b0, 1'b1,
      '{1'b1, hrf_pkg::CODE_MAX, 1'b1, 31'd7, 1'b1, 32'd7, 1'b1}},
    '{"x", 1'b0, 1'b1, 1'b1,
      '{1'b1, hrf_pkg::CODE_MAX, 1'b1, 31'd7, 1'b1, 32'd8, 1'b0}},
    '{"X 2a CContent-Length: 4294967296\015\012\015\012", 1'b1, 1'b1, 1'b0, '0},
    '{"Content-Length: -5\015\012\015\012Content-Length: 3", 1'b1, 1'b0, 1'b1,
      '{1'b1, 16'd0, 1'b0, 31'd0, 1'b0, 32'd17, 1'b0}},
    '{"Content-Length: 2147483647\015\012\015\012", 1'b1, 1'b1, 1'b1,
      '{1'b1, hrf_pkg::CODE_MAX, 1'b1, hrf_pkg::LEN_MAX, 1'b1, 32'd0, 1'b0}},
    '{"Content-Length: 0\015\012\015\012", 1'b1, 1'b0, 1'b1,
      '{1'b1, 16'd0, 1'b1, 31'd0, 1'b1, 32'd0, 1'b1}}
  };

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void clear_framing();
    sep_cnt  = '0;
    hdr_seen = 1'b0;
    code_ph  = hrf_pkg::CODE_WAIT;
    code_val = '0;
    code_dig = 1'b0;
    pfx_cnt  = '0;
    len_ph   = hrf_pkg::LEN_SEEK;
    len_val  = '0;
    len_good = 1'b0;
    body_cnt = '0;
    dropping = 1'b0;
  endfunction

  function automatic bit is_dec(logic [7:0] c);
    return c >= hrf_pkg::CHAR_0 && c <= hrf_pkg::CHAR_9;
  endfunction

  // advance the framing state by one byte and return the result it reports
  function automatic hrf_pkg::res_t frame_byte(hrf_pkg::item_t it);
    logic [7:0]    c;
    logic [31:0]   code_next;
    logic [63:0]   len_next;
    hrf_pkg::res_t r;
    c = it.data_byte;
    if (it.new_response) clear_framing();
    if (dropping) begin
      if (it.chunk_end) dropping = 1'b0;
    end else if (c == hrf_pkg::CHAR_NUL) begin
      dropping = !it.chunk_end;
    end else if (hdr_seen) begin
      if (body_cnt < BODY_MAX) body_cnt = body_cnt + 64'd1;
    end else begin
      // status code after the first space
      case (code_ph)
        hrf_pkg::CODE_WAIT: begin
          if (c == hrf_pkg::CHAR_SP) code_ph = hrf_pkg::CODE_DIGITS;
        end
        hrf_pkg::CODE_DIGITS: begin
          if (is_dec(c)) begin
            code_next = 32'(code_val) * 32'd10 + 32'(c - hrf_pkg::CHAR_0);
            code_val  = (code_next > 32'(hrf_pkg::CODE_MAX)) ? hrf_pkg::CODE_MAX
                                                             : code_next[15:0];
            code_dig  = 1'b1;
          end else begin
            code_ph = hrf_pkg::CODE_DONE;
          end
        end
        default: ;
      endcase
      // length prefix match, then decimal value
      case (len_ph)
        hrf_pkg::LEN_SEEK: begin
          if (c == hrf_pkg::PREFIX_STR[8 * (15 - int'(pfx_cnt[3:0])) +: 8]) begin
            pfx_cnt = pfx_cnt + 5'd1;
            if (pfx_cnt >= 5'd16) begin
              pfx_cnt = '0;
              len_ph  = hrf_pkg::LEN_DIGITS;
            end
          end else begin
            pfx_cnt = (c == hrf_pkg::CHAR_C) ? 5'd1 : 5'd0;
          end
        end
        hrf_pkg::LEN_DIGITS: begin
          if (is_dec(c)) begin
            len_next = 64'(len_val) * 64'd10 + 64'(c - hrf_pkg::CHAR_0);
            if (len_next > 64'(hrf_pkg::LEN_MAX)) begin
              len_good = 1'b0;
              len_ph   = hrf_pkg::LEN_DONE;
            end else begin
              len_val  = len_next[30:0];
              len_good = 1'b1;
            end
          end else if (!len_good && (c == hrf_pkg::CHAR_SP || c == hrf_pkg::CHAR_TAB)) begin
            // leading blank, skipped
          end else begin
            len_ph = hrf_pkg::LEN_DONE;
          end
        end
        default: ;
      endcase
      // header terminator
      if (c == (sep_cnt[0] ? hrf_pkg::CHAR_LF : hrf_pkg::CHAR_CR)) begin
        sep_cnt = sep_cnt + 3'd1;
        if (sep_cnt >= 3'd4) begin
          sep_cnt  = '0;
          hdr_seen = 1'b1;
        end
      end else begin
        sep_cnt = (c == hrf_pkg::CHAR_CR) ? 3'd1 : 3'd0;
      end
    end
    r.header_valid   = hdr_seen;
    r.status_code    = code_val;
    r.code_valid     = code_dig;
    r.content_length = len_val;
    r.length_valid   = len_good;
    r.body_bytes     = (body_cnt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : body_cnt[31:0];
    r.data_complete  = hdr_seen && len_good && (body_cnt == 64'(len_val));
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // result check and prediction of accepted bytes
  always @(posedge clk_i) begin : monitor
    hrf_pkg::res_t  want;
    hrf_pkg::item_t taken;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (framing_due.size() == 0) begin
          $error("result item with nothing expected");
          mismatches++;
        end else begin
          want = framing_due.pop_front();
          check_field("header_valid", want.header_valid, out_if.header_valid);
          check_field("status_code", want.status_code, out_if.status_code);
          check_field("code_valid", want.code_valid, out_if.code_valid);
          check_field("content_length", want.content_length, out_if.content_length);
          check_field("length_valid", want.length_valid, out_if.length_valid);
          check_field("body_bytes", want.body_bytes, out_if.body_bytes);
          check_field("data_complete", want.data_complete, out_if.data_complete);
        end
      end
      if (in_if.valid && in_if.ready) begin
        taken.data_byte    = in_if.data_byte;
        taken.chunk_end    = in_if.chunk_end;
        taken.new_response = in_if.new_response;
        want = frame_byte(taken);
        if (pin_on) want = pin_res;
        framing_due.push_back(want);
      end
    end
  end

  // offer one byte, in bursts with random gaps between them
  task automatic offer_byte(hrf_pkg::item_t it, bit pinned, hrf_pkg::res_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        in_if.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    in_if.valid        <= 1'b1;
    in_if.data_byte    <= it.data_byte;
    in_if.chunk_end    <= it.chunk_end;
    in_if.new_response <= it.new_response;
    pin_on  = pinned;
    pin_res = want;
    do @(posedge clk_i); while (!in_if.ready);
    bytes_sent++;
  endtask

  // queue one byte with random chunking and an occasional stray NUL
  task automatic add_byte(logic [7:0] b);
    hrf_pkg::item_t it;
    if ($urandom_range(0, 59) == 0) begin
      it.data_byte    = hrf_pkg::CHAR_NUL;
      it.chunk_end    = ($urandom_range(0, 3) == 0);
      it.new_response = 1'b0;
      pending.push_back(it);
    end
    it.data_byte    = b;
    it.chunk_end    = ($urandom_range(0, 7) == 0);
    it.new_response = 1'b0;
    pending.push_back(it);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // one response: mostly well formed with random content, some noise
  task automatic build_response();
    int unsigned target;
    int unsigned body_len;
    string       num;
    string       tag;
    string       blanks;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(4, 40)) add_byte(8'($urandom_range(0, 255)));
    end else begin
      add_text("HTTP/1.1 ");
      case ($urandom_range(0, 5))
        0: add_text($sformatf("%0d", $urandom_range(65530, 999999)));
        1: add_text("2x0");
        2: ;
        default: add_text($sformatf("%0d", $urandom_range(100, 599)));
      endcase
      add_text(" OK\015\012");
      if ($urandom_range(0, 2) == 0) add_text({"X-Tag: ", $sformatf("%0h", $urandom), "\015\012"});
      target = $urandom_range(0, 24);
      case ($urandom_range(0, 9))
        0: num = "";
        1: num = $urandom_range(0, 1) ? "-3" : "+12";
        2: num = $sformatf("%0d", $urandom_range(0, 32'h7FFF_FFFF));
        3: num = $urandom_range(0, 1) ? "2147483647" : "2147483648";
        4: num = $sformatf("%0d%05d", $urandom_range(21475, 99999), $urandom_range(0, 99999));
        default: num = $sformatf("%0d", target);
      endcase
      case ($urandom_range(0, 3))
        0: blanks = " ";
        1: blanks = "\011 ";
        default: blanks = "";
      endcase
      case ($urandom_range(0, 9))
        0: tag = "";
        1: tag = "content-Length: ";
        2: tag = "Content-Length:";
        3: tag = "CContent-Length: ";
        default: tag = "Content-Length: ";
      endcase
      if (tag.len() != 0) add_text({tag, blanks, num, "\015\012"});
      if ($urandom_range(0, 1) == 0) add_text("Server: x\015\012");
      add_text(($urandom_range(0, 9) == 0) ? "\015\015\012" : "\015\012");
      case ($urandom_range(0, 5))
        0: body_len = target + 1;
        1: body_len = (target > 0) ? target - 1 : 0;
        default: body_len = target;
      endcase
      repeat (body_len) add_byte(8'($urandom_range(1, 255)));
    end
    if ($urandom_range(0, 9) != 0) pending[0].new_response = 1'b1;
  endtask

  // receiver: long hold-off early on, then a pattern of stalls
  initial begin : result_sink
    sink_mode_e  mode;
    int unsigned span;
    int unsigned tick;
    out_if.ready = 1'b0;
    tick = 0;
    @(posedge rst_ni);
    repeat (120) begin
      @(negedge clk_i);
      out_if.ready <= ($urandom_range(0, 3) != 0);
    end
    // output register fills up and the input stalls
    repeat (LONG_HOLD) begin
      @(negedge clk_i);
      out_if.ready <= 1'b0;
    end
    forever begin
      mode = sink_mode_e'($urandom_range(0, 3));
      span = $urandom_range(8, 80);
      repeat (span) begin
        @(negedge clk_i);
        tick++;
        case (mode)
          SINK_OPEN:  out_if.ready <= 1'b1;
          SINK_COIN:  out_if.ready <= 1'($urandom_range(0, 1));
          SINK_THIRD: out_if.ready <= (tick % 3 == 0);
          default:    out_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    hrf_pkg::item_t it;
    int unsigned    row_len;
    int unsigned    dir_bytes;
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.data_byte    = '0;
    in_if.chunk_end    = 1'b0;
    in_if.new_response = 1'b0;
    pin_on             = 1'b0;
    pin_res            = '0;
    burst_left         = 0;
    bytes_sent         = 0;
    mismatches         = 0;
    clear_framing();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed rows
    foreach (dir_rows[r]) begin
      row_len = dir_rows[r].text.len();
      for (int i = 0; i < row_len; i++) begin
        it.data_byte    = (dir_rows[r].text[i] == "@") ? hrf_pkg::CHAR_NUL
                                                       : dir_rows[r].text[i];
        it.chunk_end    = dir_rows[r].closes_chunk && (i == row_len - 1);
        it.new_response = dir_rows[r].fresh && (i == 0);
        offer_byte(it, dir_rows[r].pinned && (i == row_len - 1), dir_rows[r].want);
      end
    end
    dir_bytes = bytes_sent;

    // random responses
    while (bytes_sent < dir_bytes + RANDOM_BYTES) begin
      build_response();
      while (pending.size() != 0) offer_byte(pending.pop_front(), 1'b0, '0);
    end
    @(negedge clk_i);
    in_if.valid <= 1'b0;

    while (framing_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== http_response_framer_unit.f =====
+incdir+rtl
rtl/hrf_pkg.sv
rtl/hrf_in_if.sv
rtl/hrf_out_if.sv
rtl/hrf_core.sv
rtl/http_response_framer_unit.sv
bench/tb.sv
